// ===== hdl/rpn_stack_evaluator_top_macros.svh =====
// Assertion macros used by the checker file of the RPN evaluator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef RPN_STACK_EVALUATOR_TOP_MACROS_SVH
`define RPN_STACK_EVALUATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn evaluator check failed");

// Consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpn evaluator check failed");

`endif

// ===== hdl/rpn_pkg.sv =====
// Shared constants, types and helper functions of the RPN stack evaluator.
// Used by every module of the block; depends on nothing else.
package rpn_pkg;

    // Stack geometry and field widths.
    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 7;
    localparam int OP_W        = 3;
    localparam int CNT_W       = $clog2(DATA_W);

    // Token opcodes; codes above OP_DIV are ignored.
    localparam logic [OP_W-1:0] OP_PUSH = OP_W'(0);
    localparam logic [OP_W-1:0] OP_ADD  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_SUB  = OP_W'(2);
    localparam logic [OP_W-1:0] OP_MUL  = OP_W'(3);
    localparam logic [OP_W-1:0] OP_DIV  = OP_W'(4);

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_FULL      = 2'd2,
        ST_DIVZERO   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV
    } state_t;

    // Divider request and response.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    // Absolute value of a two's complement word, wrapping for the most negative value.
    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

endpackage

// ===== hdl/rpn_stack_evaluator_top.sv =====
// Top level of the RPN stack evaluator: token sequencer, output register and datapath.
// Depends on rpn_pkg, rpn_stack_ram and rpn_divider.
//
//  Channel   Direction  Fields (low bit first)
//  s_axis    in         tdata: number[31:0]; tuser: opcode[2:0]; tlast: last_token
//  m_axis    out        tdata: top_value[31:0], stack_depth[38:32], zero[39];
//                       tuser: status[1:0]; tlast: expression_done
//
// A push, an ignored opcode or a token that is rejected (underflow, full, divide by
// zero) completes in the cycle it is accepted; such tokens transfer back to back.
// Add, subtract and multiply pass through S_READ as the second operand comes from
// the stack RAM read port. A divide goes through the RAM read, loading the divider,
// 32 steps of the bit-serial divider, and the write back. Reset clears the stack
// pointer and the control state; the stack RAM is not cleared. A result waiting in
// the output register blocks the next token only if it is not taken in the same cycle.
module rpn_stack_evaluator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // number[31:0]
    input  logic [2:0]  s_axis_tuser,   // opcode[2:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // top_value[31:0], stack_depth[38:32], zero[39]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);
    import rpn_pkg::*;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  sp_reg, sp_next;
    logic [DATA_W-1:0] tos_reg, tos_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic              last_reg, last_next;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_top_reg, out_top_next;
    logic [DEPTH_W-1:0] out_depth_reg, out_depth_next;
    status_t           out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              accept;
    logic [PTR_W-1:0]  sp_less2;
    logic [DATA_W-1:0] alu;
    logic              fin;
    logic [PTR_W-1:0]  fin_sp;
    logic [DATA_W-1:0] fin_tos;
    status_t           fin_status;
    logic              fin_last;

    rpn_stack_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rpn_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // A token is taken only when idle and the output slot is free by the next edge.
    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sp_less2      = sp_reg - PTR_W'(2);

    // Add, subtract and multiply on the second entry from RAM and the cached top.
    always_comb
    begin
        unique case (op_reg)
            OP_ADD:  alu = ram_rdata + tos_reg;
            OP_SUB:  alu = ram_rdata - tos_reg;
            OP_MUL:  alu = DATA_W'(ram_rdata * tos_reg);
            default: alu = '0;
        endcase
    end

    // Sequencer: next state, stack updates and result formation.
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        ram_we           = 1'b0;
        ram_waddr        = sp_less2[ADDR_W-1:0];
        ram_wdata        = alu;
        ram_re           = 1'b0;
        ram_raddr        = sp_less2[ADDR_W-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = ram_rdata;
        div_req.divisor  = tos_reg;
        fin              = 1'b0;
        fin_sp           = sp_reg;
        fin_tos          = tos_reg;
        fin_status       = ST_OK;
        fin_last         = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fin_last = s_axis_tlast;
                    if (s_axis_tuser == OP_PUSH)
                    begin
                        fin = 1'b1;
                        if (sp_reg == PTR_W'(STACK_DEPTH))
                        begin
                            fin_status = ST_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = sp_reg[ADDR_W-1:0];
                            ram_wdata = s_axis_tdata;
                            fin_tos   = s_axis_tdata;
                            fin_sp    = sp_reg + PTR_W'(1);
                        end
                    end
                    else if ((s_axis_tuser >= OP_ADD) && (s_axis_tuser <= OP_DIV))
                    begin
                        if (sp_reg < PTR_W'(2))
                        begin
                            fin        = 1'b1;
                            fin_status = ST_UNDERFLOW;
                        end
                        else if ((s_axis_tuser == OP_DIV) && (tos_reg == '0))
                        begin
                            fin        = 1'b1;
                            fin_status = ST_DIVZERO;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            op_next    = s_axis_tuser;
                            last_next  = s_axis_tlast;
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        // Unused opcodes leave the stack alone.
                        fin = 1'b1;
                    end
                end
            end

            S_READ:
            begin
                if (op_reg == OP_DIV)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    fin        = 1'b1;
                    ram_we     = 1'b1;
                    fin_tos    = alu;
                    fin_sp     = sp_reg - PTR_W'(1);
                    state_next = S_IDLE;
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    fin        = 1'b1;
                    ram_we     = 1'b1;
                    ram_wdata  = div_rsp.quotient;
                    fin_tos    = div_rsp.quotient;
                    fin_sp     = sp_reg - PTR_W'(1);
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Commit the token and load the output register.
        sp_next  = fin ? (fin_last ? '0 : fin_sp) : sp_reg;
        tos_next = fin_tos;

        out_top_next    = out_top_reg;
        out_depth_next  = out_depth_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (fin)
        begin
            out_top_next    = (fin_sp != '0) ? fin_tos : '0;
            out_depth_next  = DEPTH_W'(fin_sp);
            out_status_next = fin_status;
            out_last_next   = fin_last;
        end

        if (fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tos_reg        <= tos_next;
        op_reg         <= op_next;
        last_reg       <= last_next;
        out_top_reg    <= out_top_next;
        out_depth_reg  <= out_depth_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_depth_reg, out_top_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== hdl/rpn_stack_ram.sv =====
// Operand stack storage: one write port and one registered read port.
// Depends on rpn_pkg for depth and widths.
module rpn_stack_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [rpn_pkg::ADDR_W-1:0] waddr,
    input  logic [rpn_pkg::DATA_W-1:0] wdata,
    input  logic                       re,
    input  logic [rpn_pkg::ADDR_W-1:0] raddr,
    output logic [rpn_pkg::DATA_W-1:0] rdata
);
    import rpn_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write, and read into a registered read data output.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rpn_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg for widths, request/response types and magnitude().
module rpn_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::div_req_t req,
    output rpn_pkg::div_rsp_t rsp
);
    import rpn_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              qbit;
    logic [DATA_W-1:0] rem_step;
    logic [DATA_W-1:0] quo_step;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DATA_W-1]};
        diff     = shifted - {1'b0, den_reg};
        qbit     = ~diff[DATA_W];
        rem_step = qbit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        quo_step = {quo_reg[DATA_W-2:0], qbit};
    end

    // Control: busy while iterating, done pulses once after the last step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: operands as magnitudes, sign applied at the output.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= magnitude(req.dividend);
            den_reg <= magnitude(req.divisor);
            neg_reg <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            quo_reg <= quo_step;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

// ===== hdl/rpn_checker.sv =====
// Port-level checks of the RPN stack evaluator, bound to its top level.
// Depends on rpn_pkg and on the assertion macros header.
`include "rpn_stack_evaluator_top_macros.svh"

module rpn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import rpn_pkg::*;

    // A stalled result stays put.
    `RPN_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // An empty stack reports a zero top.
    `RPN_ASSERT_SAME(a_empty_top, m_axis_tvalid && (m_axis_tdata[38:32] == '0), m_axis_tdata[31:0] == '0)

    // Underflow only happens with fewer than two entries.
    `RPN_ASSERT_SAME(a_underflow_depth, m_axis_tvalid && (m_axis_tuser == ST_UNDERFLOW), m_axis_tdata[38:32] < DEPTH_W'(2))

    // A full report means the stack is at its limit.
    `RPN_ASSERT_SAME(a_full_depth, m_axis_tvalid && (m_axis_tuser == ST_FULL), m_axis_tdata[38:32] == DEPTH_W'(STACK_DEPTH))

endmodule

bind rpn_stack_evaluator_top rpn_checker u_rpn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
